// File: design/scrollback_row_tracker_macros.svh
// ----------------------------------------------------------------------------
// Scrollback row tracker assertion macros
// Shared forms for the concurrent checks of the design files.
// ----------------------------------------------------------------------------
`ifndef SCROLLBACK_ROW_TRACKER_MACROS_SVH
`define SCROLLBACK_ROW_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// Scrollback row tracker package
// Payload types, command codes, sizes and the matcher state type.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 256;
	localparam int RowW = 7;
	localparam int ColCfgW = 9;
	localparam int CharW = 16;
	localparam logic [ColCfgW-1:0] COLS_RESET = 9'd80;

	localparam logic [1:0] CMD_CHAR  = 2'd0;
	localparam logic [1:0] CMD_EMPTY = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [CharW-1:0] char_code;
		logic [RowW-1:0]  rows;
		logic             last_char;
		logic [5:0]       query_row;
		logic [7:0]       query_col;
	} in_item_t;

	typedef struct packed {
		logic            kind;
		logic            valid_res;
		logic [31:0]     global_line;
		logic [7:0]      column;
		logic [RowW-1:0] matched_rows;
	} out_item_t;

	typedef struct packed {
		logic            done;
		logic            found;
		logic [RowW-1:0] first;
	} match_res_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_SCAN,
		M_CMP
	} match_state_t;

endpackage

// File: design/srt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/srt_match.sv
// ----------------------------------------------------------------------------
// Scrollback row tracker matcher
// Walks candidate start rows of the stored frame and compares the stored
// tail with the head of the new frame, one character per cycle.
// ----------------------------------------------------------------------------
`include "scrollback_row_tracker_macros.svh"

module srt_match #(
	parameter int MAX_ROWS = srt_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = srt_pkg::MAX_COLS_DEF,
	localparam int DEPTH = MAX_ROWS * MAX_COLS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srt_pkg::RowW-1:0]      row_cnt,
	input  logic [LW-1:0]                 slen,
	input  logic [LW-1:0]                 flen,
	input  logic [srt_pkg::ColCfgW-1:0]   cols,
	input  logic [srt_pkg::CharW-1:0]     s_rdata,
	input  logic [srt_pkg::CharW-1:0]     f_rdata,
	output logic [AW-1:0]                 s_raddr,
	output logic [AW-1:0]                 f_raddr,
	output logic                          busy,
	output srt_pkg::match_res_t           res
);

	import srt_pkg::*;

	match_state_t state_q, state_d;
	logic [RowW-1:0] first_q;
	logic [LW-1:0]   sbase_q;
	logic [LW-1:0]   sa_q;
	logic [LW-1:0]   fa_q;
	logic            iss_q;
	logic            pend_s1;
	logic            last_s1;

	logic scan_end, scan_skip, cmp_fail, cmp_hit;

	assign scan_end  = first_q >= row_cnt;
	assign scan_skip = (slen - sbase_q) > flen;
	assign cmp_fail  = pend_s1 && (s_rdata != f_rdata);
	assign cmp_hit   = pend_s1 && last_s1 && (s_rdata == f_rdata);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: begin
				if (start) begin
					state_d = M_SCAN;
				end
			end
			M_SCAN: begin
				if (scan_end) begin
					state_d = M_IDLE;
				end else if (!scan_skip) begin
					state_d = M_CMP;
				end
			end
			M_CMP: begin
				if (cmp_fail) begin
					state_d = M_SCAN;
				end else if (cmp_hit) begin
					state_d = M_IDLE;
				end
			end
			default: state_d = M_IDLE;
		endcase
	end

	always_comb begin
		res       = '0;
		res.first = first_q;
		busy      = state_q != M_IDLE;
		s_raddr   = sa_q[AW-1:0];
		f_raddr   = fa_q[AW-1:0];
		unique case (state_q)
			M_SCAN: begin
				res.done = scan_end;
			end
			M_CMP: begin
				res.done  = cmp_hit;
				res.found = cmp_hit;
			end
			default: begin
				res.done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			pend_s1 <= 1'b0;
			iss_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == M_CMP && iss_q && !cmp_fail) begin
				pend_s1 <= 1'b1;
				iss_q   <= sa_q != slen - LW'(1);
			end else begin
				pend_s1 <= 1'b0;
				if (state_q == M_SCAN) begin
					iss_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE) begin
			first_q <= '0;
			sbase_q <= '0;
		end else if ((state_q == M_SCAN && !scan_end && scan_skip) ||
				(state_q == M_CMP && cmp_fail)) begin
			first_q <= first_q + RowW'(1);
			sbase_q <= sbase_q + LW'(cols);
		end
		if (state_q == M_SCAN) begin
			sa_q <= sbase_q;
			fa_q <= '0;
		end else if (iss_q) begin
			sa_q <= sa_q + LW'(1);
			fa_q <= fa_q + LW'(1);
		end
		last_s1 <= sa_q == slen - LW'(1);
	end

	`SRT_ASSERT_IMP(a_addr_track, state_q == M_CMP && iss_q, sa_q - sbase_q == fa_q, "read addresses out of step")
	`SRT_ASSERT_IMP(a_first_range, res.found, first_q < row_cnt, "match start beyond stored rows")
	`SRT_ASSERT_NXT(a_done_idle, res.done, state_q == M_IDLE && !pend_s1, "matcher not idle after done")

endmodule

// File: design/scrollback_row_tracker.sv
// ----------------------------------------------------------------------------
// Scrollback row tracker
// Tracks screen frames against the previous frame to follow scrolling.
// ----------------------------------------------------------------------------
// Frame characters are taken one per cycle while in_ready is high and written
// into the idle bank of two frame memories; queries, empty frames and
// rejected frames answer in the next cycle. At the end of an accepted frame
// the matcher walks candidate start rows, skipping each one that cannot fit
// and comparing the others at one character per cycle over both memory read
// ports; the banks then swap roles, so no copy is made. No clearing pass is
// needed after reset.
`include "scrollback_row_tracker_macros.svh"

module scrollback_row_tracker #(
	parameter int MAX_ROWS = srt_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = srt_pkg::MAX_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  srt_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output srt_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [srt_pkg::ColCfgW-1:0] cfg_wdata
);

	import srt_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int WPW = $clog2(DEPTH + 2);

	logic [ColCfgW-1:0] cols_q;
	logic [31:0]        top_q;
	logic [RowW-1:0]    scount_q;
	logic [RowW-1:0]    vis_q;
	logic [LW-1:0]      slen_q;
	logic [WPW-1:0]     wp_q;
	logic               sel_q;
	logic               fin_pend_q;
	logic               found_q;
	logic [RowW-1:0]    first_q;
	logic [RowW-1:0]    nrows_q;
	logic [LW-1:0]      flen_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               acc, out_free, busy;
	logic               is_char, frame_end, frame_empty, frame_bad, frame_go, fin_go;
	logic               fwe;
	logic [WPW-1:0]     wp_next;
	logic [ColCfgW+RowW-1:0] prod;
	logic [AW-1:0]      s_raddr, f_raddr;
	logic [CharW-1:0]   rd0, rd1, s_rdata, f_rdata;
	logic [31:0]        top_fin;
	logic               out_load;
	out_item_t          out_d;
	match_res_t         mres;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !busy && !fin_pend_q && out_free;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_char     = acc && in_data.cmd == CMD_CHAR;
	assign frame_end   = is_char && in_data.last_char;
	assign wp_next     = (32'(wp_q) <= DEPTH) ? wp_q + WPW'(1) : wp_q;
	assign fwe         = is_char && 32'(wp_q) < DEPTH;
	assign prod        = cols_q * in_data.rows;
	assign frame_empty = cols_q == '0 || in_data.rows == '0;
	assign frame_bad   = int'(cols_q) > MAX_COLS || int'(in_data.rows) > MAX_ROWS ||
		32'(prod) != 32'(wp_next);
	assign frame_go    = frame_end && !frame_empty && !frame_bad;
	assign fin_go      = fin_pend_q && out_free;
	assign top_fin     = top_q + 32'(found_q ? first_q : scount_q);

	// Bank sel_q holds the stored rows; the other bank takes the new frame.
	srt_ram #(.WIDTH(CharW), .DEPTH(DEPTH)) u_ram0 (
		.clk  (clk),
		.we   (fwe && sel_q),
		.waddr(wp_q[AW-1:0]),
		.wdata(in_data.char_code),
		.raddr(sel_q ? f_raddr : s_raddr),
		.rdata(rd0)
	);

	srt_ram #(.WIDTH(CharW), .DEPTH(DEPTH)) u_ram1 (
		.clk  (clk),
		.we   (fwe && !sel_q),
		.waddr(wp_q[AW-1:0]),
		.wdata(in_data.char_code),
		.raddr(sel_q ? s_raddr : f_raddr),
		.rdata(rd1)
	);

	assign s_rdata = sel_q ? rd1 : rd0;
	assign f_rdata = sel_q ? rd0 : rd1;

	srt_match #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (frame_go),
		.row_cnt(scount_q),
		.slen   (slen_q),
		.flen   (flen_q),
		.cols   (cols_q),
		.s_rdata(s_rdata),
		.f_rdata(f_rdata),
		.s_raddr(s_raddr),
		.f_raddr(f_raddr),
		.busy   (busy),
		.res    (mres)
	);

	always_comb begin
		out_load = 1'b0;
		out_d    = '0;
		if (fin_go) begin
			out_load           = 1'b1;
			out_d.kind         = KIND_FRAME;
			out_d.valid_res    = 1'b1;
			out_d.global_line  = top_fin;
			out_d.matched_rows = found_q ? scount_q - first_q : '0;
		end else if (acc) begin
			case (in_data.cmd)
				CMD_CHAR: begin
					out_load          = frame_end && !frame_go;
					out_d.kind        = KIND_FRAME;
					out_d.valid_res   = frame_empty || !frame_bad;
					out_d.global_line = top_q;
				end
				CMD_EMPTY: begin
					out_load          = 1'b1;
					out_d.kind        = KIND_FRAME;
					out_d.valid_res   = 1'b1;
					out_d.global_line = top_q;
				end
				CMD_QUERY: begin
					out_load   = 1'b1;
					out_d.kind = KIND_QUERY;
					if (RowW'(in_data.query_row) < vis_q) begin
						out_d.valid_res   = 1'b1;
						out_d.global_line = top_q + 32'(in_data.query_row);
						out_d.column      = in_data.query_col;
					end
				end
				default: out_load = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= COLS_RESET;
			top_q       <= '0;
			scount_q    <= '0;
			vis_q       <= '0;
			slen_q      <= '0;
			wp_q        <= '0;
			sel_q       <= 1'b0;
			fin_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cols_q <= cfg_wdata;
			end
			if (cfg_we && cfg_wdata != cols_q) begin
				top_q    <= top_q + 32'(scount_q);
				scount_q <= '0;
				vis_q    <= '0;
				slen_q   <= '0;
			end else if (fin_go) begin
				top_q    <= top_fin;
				scount_q <= nrows_q;
				vis_q    <= nrows_q;
				slen_q   <= flen_q;
				sel_q    <= !sel_q;
			end else if ((frame_end && frame_empty) ||
					(acc && in_data.cmd == CMD_EMPTY)) begin
				vis_q <= '0;
			end
			if (frame_end || (acc && in_data.cmd == CMD_EMPTY)) begin
				wp_q <= '0;
			end else if (is_char) begin
				wp_q <= wp_next;
			end
			if (mres.done) begin
				fin_pend_q <= 1'b1;
			end else if (fin_go) begin
				fin_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		if (frame_go) begin
			nrows_q <= in_data.rows;
			flen_q  <= LW'(wp_next);
		end
		if (mres.done) begin
			found_q <= mres.found;
			first_q <= mres.first;
		end
	end

	`SRT_ASSERT_IMP(a_done_free, mres.done, !fin_pend_q, "match result while one is pending")
	`SRT_ASSERT_IMP(a_ready_idle, in_ready, !busy && !fin_pend_q, "request taken while matching")
	`SRT_ASSERT_NXT(a_start_busy, frame_go, busy, "matcher did not start on frame end")

endmodule
